// ----- hdl/mbs_pkg.sv -----
// Package: shared widths, register indexes and datapath structs for the brightness smoother.
`timescale 1ns / 1ps

package mbs_pkg;

    localparam int CH_W    = 6;   // channel field
    localparam int RAW_W   = 8;   // raw target field
    localparam int TIME_W  = 16;  // elapsed time field
    localparam int RATE_W  = 8;
    localparam int LVL_W   = 16;  // level format, full scale = 2^LVL_W - 1
    localparam int STEP_W  = 17;  // step factor, Q.16 up to 1.0
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 16;

    localparam logic [LVL_W-1:0]   FULL_LEVEL = {LVL_W{1'b1}};
    localparam logic [STEP_W-1:0]  STEP_ONE   = {1'b1, {(STEP_W-1){1'b0}}};
    localparam logic [RATE_W-1:0]  RATE_RST   = 8'd10;
    localparam logic [LVL_W-1:0]   THR_RST    = 16'd66;

    localparam logic [CFG_A_W-1:0] REG_RATE   = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_THRESH = 1'b1;

    typedef struct packed {
        logic [LVL_W-1:0]  cur;
        logic [LVL_W-1:0]  target;
        logic [STEP_W-1:0] step;
        logic [LVL_W-1:0]  thr;
    } t_upd_in;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             snapped;
    } t_upd_out;

endpackage

// ----- hdl/multichannel_brightness_smoother.sv -----
// Top level: pipelined multichannel brightness smoother with per-channel level memory.
//
//  port group   dir   tdata fields (lsb first)                 tuser
//  s_axis       in    channel[5:0] raw_level[13:6] step_time[29:14]   -
//  m_axis       out   channel_out[5:0] brightness[21:6]       snapped[0]
//  i_cfg_*      in    index 0 smoothing_rate[7:0], index 1 snap_threshold[15:0]
//
// One transaction per cycle sustained while the output is not stalled.
// Stages: input + level memory read, step multiply + forwarding, update + output register.
// A repeated channel is forwarded from the last-write register.
// Reset clears pipeline valids and per-channel valid bits at once; no clearing pass.
// A stalled output freezes the whole pipe; nothing is dropped or repeated.
`timescale 1ns / 1ps

module multichannel_brightness_smoother #(
    parameter int CHANNELS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // channel, raw_level, step_time
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [23:0]                  m_axis_tdata,  // channel_out, brightness
    output logic [0:0]                   m_axis_tuser,  // snapped
    input  logic                         i_cfg_we,
    input  logic [mbs_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  logic [mbs_pkg::CFG_D_W-1:0]  i_cfg_wdata
);
    import mbs_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // config
    logic [RATE_W-1:0] r_rate;
    logic [LVL_W-1:0]  r_thr;

    // level memory and per-entry written flags
    logic [LVL_W-1:0]    r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vb;

    // last write, for forwarding
    logic             r_w_valid;
    logic [IDX_W-1:0] r_w_idx;
    logic [LVL_W-1:0] r_w_data;

    // stage A
    logic              r_a_valid;
    logic [CH_W-1:0]   r_a_ch;
    logic [RAW_W-1:0]  r_a_raw;
    logic [TIME_W-1:0] r_a_time;
    logic [LVL_W-1:0]  r_a_rd;
    logic              r_a_vb;

    // stage B
    logic              r_b_valid;
    logic [CH_W-1:0]   r_b_ch;
    logic              r_b_inr;
    logic [LVL_W-1:0]  r_b_target;
    logic [STEP_W-1:0] r_b_step;
    logic [LVL_W-1:0]  r_b_cur;

    // output
    logic              r_o_valid;
    logic [CH_W-1:0]   r_o_ch;
    logic [LVL_W-1:0]  r_o_lvl;
    logic              r_o_snap;

    logic                      en;
    logic                      accept;
    logic [CH_W-1:0]           in_ch;
    logic [IDX_W-1:0]          rd_idx;
    logic [IDX_W-1:0]          a_idx;
    logic [IDX_W-1:0]          b_idx;
    logic [RATE_W+TIME_W-1:0]  step_raw;
    logic [STEP_W-1:0]         n_step;
    logic [LVL_W-1:0]          a_rst_val;
    logic [LVL_W-1:0]          n_cur_b;
    logic [LVL_W-1:0]          n_cur_c;
    logic                      wr_en;
    t_upd_in                   upd_in;
    t_upd_out                  upd_out;

    assign en            = !r_o_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    assign in_ch  = s_axis_tdata[CH_W-1:0];
    assign rd_idx = IDX_W'(in_ch);
    assign a_idx  = IDX_W'(r_a_ch);
    assign b_idx  = IDX_W'(r_b_ch);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RST;
            r_thr  <= THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RATE:   r_rate <= i_cfg_wdata[RATE_W-1:0];
                REG_THRESH: r_thr  <= i_cfg_wdata[LVL_W-1:0];
                default:    ;
            endcase
        end
    end

    // stage A: capture transaction, read level memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ch   <= in_ch;
            r_a_raw  <= s_axis_tdata[CH_W+RAW_W-1:CH_W];
            r_a_time <= s_axis_tdata[CH_W+RAW_W+TIME_W-1:CH_W+RAW_W];
            r_a_rd   <= r_mem[rd_idx];
            r_a_vb   <= r_vb[rd_idx];
        end
    end

    // stage B: step factor, target, level with forwarding of the write made during the read
    assign step_raw  = r_a_time * r_rate;
    assign n_step    = (step_raw > (RATE_W+TIME_W)'(STEP_ONE)) ? STEP_ONE
                                                              : step_raw[STEP_W-1:0];
    assign a_rst_val = (a_idx == '0) ? FULL_LEVEL : '0;
    assign n_cur_b   = (r_w_valid && r_w_idx == a_idx) ? r_w_data
                     : (r_a_vb ? r_a_rd : a_rst_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ch     <= r_a_ch;
            r_b_inr    <= {{(32-CH_W){1'b0}}, r_a_ch} < 32'(CHANNELS);
            r_b_target <= {r_a_raw, r_a_raw};  // raw * 257
            r_b_step   <= n_step;
            r_b_cur    <= n_cur_b;
        end
    end

    // stage C: update, covering the write made while this item sat in stage B
    assign n_cur_c = (r_w_valid && r_w_idx == b_idx) ? r_w_data : r_b_cur;

    assign upd_in.cur    = n_cur_c;
    assign upd_in.target = r_b_target;
    assign upd_in.step   = r_b_step;
    assign upd_in.thr    = r_thr;

    mbs_update u_update (
        .i_upd (upd_in),
        .o_upd (upd_out)
    );

    assign wr_en = en && r_b_valid && r_b_inr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[b_idx] <= upd_out.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb      <= '0;
            r_w_valid <= 1'b0;
        end else if (wr_en) begin
            r_vb[b_idx] <= 1'b1;
            r_w_valid   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_w_idx  <= b_idx;
            r_w_data <= upd_out.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_ch   <= r_b_ch;
            r_o_lvl  <= r_b_inr ? upd_out.level : '0;
            r_o_snap <= r_b_inr && upd_out.snapped;
        end
    end

    assign m_axis_tvalid   = r_o_valid;
    assign m_axis_tdata    = {2'b00, r_o_lvl, r_o_ch};
    assign m_axis_tuser[0] = r_o_snap;

endmodule

// ----- hdl/mbs_update.sv -----
// Level update: snap test, step multiply, floor shift and clamp for one channel.
`timescale 1ns / 1ps

module mbs_update (
    input  mbs_pkg::t_upd_in  i_upd,
    output mbs_pkg::t_upd_out o_upd
);
    import mbs_pkg::*;

    logic signed [LVL_W:0]          diff;
    logic        [LVL_W:0]          adiff;
    logic signed [LVL_W+STEP_W:0]   prod;
    logic signed [LVL_W+STEP_W-16:0] move;
    logic signed [LVL_W+3:0]        sum;
    logic        [LVL_W-1:0]        clamped;
    logic                           snap;

    assign diff  = $signed({1'b0, i_upd.target}) - $signed({1'b0, i_upd.cur});
    assign adiff = diff[LVL_W] ? (LVL_W+1)'(-diff) : diff;
    assign snap  = adiff < {1'b0, i_upd.thr};

    assign prod = diff * $signed({1'b0, i_upd.step});
    // arithmetic right shift by 16 rounds toward negative infinity
    assign move = prod[LVL_W+STEP_W:16];
    assign sum  = $signed({4'b0000, i_upd.cur})
                + $signed({{(LVL_W+4-$bits(move)){move[$bits(move)-1]}}, move});

    always_comb begin
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > $signed({4'b0000, FULL_LEVEL})) begin
            clamped = FULL_LEVEL;
        end else begin
            clamped = sum[LVL_W-1:0];
        end
    end

    assign o_upd.level   = snap ? i_upd.target : clamped;
    assign o_upd.snapped = snap;

endmodule

// ----- hdl/mbs_checker.sv -----
// Port-level checker for the brightness smoother, bound to the top level.
`timescale 1ns / 1ps

module mbs_checker #(
    parameter int CHANNELS = 64
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [23:0]                  m_axis_tdata,
    input logic [0:0]                   m_axis_tuser
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // input side only backs off when the output register is blocked
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // a snapped level is a scaled 8-bit target: both bytes equal
    a_snap_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[21:14] == m_axis_tdata[13:6])
        else $error("snapped level is not a scaled target");

    // nonexistent channel reports zero and no snap
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ({26'b0, m_axis_tdata[5:0]} >= 32'(CHANNELS)) |->
            m_axis_tdata[21:6] == '0 && !m_axis_tuser[0])
        else $error("out-of-range channel changed level");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind multichannel_brightness_smoother mbs_checker #(.CHANNELS(CHANNELS)) u_mbs_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the multichannel brightness smoother stream block.
`timescale 1ns / 1ps

module tb_top;
    import mbs_pkg::*;

    localparam int RUN_LIMIT  = 400_000;  // cycles, far above the slowest legal run
    localparam int PRINT_CAP  = 20;
    localparam int N_PHASES   = 10;
    localparam int PHASE_ITEMS = 115;

    typedef enum logic [1:0] {RX_FREE, RX_PATTERN, RX_RANDOM} t_rx_mode;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [LVL_W-1:0] level;
        logic             snap;
    } t_lvl_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // channel, raw_level, step_time
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;   // channel_out, brightness
    logic [0:0]           m_axis_tuser;   // snapped
    logic                 i_cfg_we;
    logic [CFG_A_W-1:0]   i_cfg_addr;
    logic [CFG_D_W-1:0]   i_cfg_wdata;

    // Predictor state
    logic [LVL_W-1:0]     chan_level [64];
    logic [RATE_W-1:0]    cfg_rate;
    logic [LVL_W-1:0]     cfg_thresh;
    t_lvl_result          pending_levels [$];

    // Traffic shaping
    int                   burst_left;
    int                   tx_gap_max;
    t_rx_mode             rx_mode;
    logic [15:0]          rx_mask;
    logic [3:0]           rx_phase;
    int                   rx_stall_pct;

    int                   items_sent;
    int                   levels_checked;
    int                   mismatches;
    int                   phases_run;
    int                   cycle_count;

    multichannel_brightness_smoother dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d levels still pending",
                     cycle_count, pending_levels.size());
            $display("[multichannel_brightness_smoother] ERROR");
            $finish;
        end
    end

    // Output side stall generator
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 4'd1;
        case (rx_mode)
            RX_PATTERN: begin
                m_axis_tready <= rx_mask[rx_phase];
            end
            RX_RANDOM: begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
            default: begin
                m_axis_tready <= 1'b1;
            end
        endcase
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch @%0d: %s got %0d exp %0d", cycle_count, what, got, want);
    endtask

    // Next level of one channel; updates the predictor state
    function automatic t_lvl_result next_level(input logic [CH_W-1:0] ch,
                                               input logic [RAW_W-1:0] raw,
                                               input logic [TIME_W-1:0] dt);
        t_lvl_result res;
        longint tgt, cur, dlt, mag, stp, nxt;
        tgt = longint'(raw) * longint'(FULL_LEVEL) / 255;
        cur = longint'(chan_level[ch]);
        dlt = tgt - cur;
        mag = (dlt < 0) ? -dlt : dlt;
        res.ch = ch;
        if (mag < longint'(cfg_thresh)) begin
            nxt = tgt;
            res.snap = 1'b1;
        end else begin
            stp = longint'(cfg_rate) * longint'(dt);
            if (stp > longint'(STEP_ONE))
                stp = longint'(STEP_ONE);
            // arithmetic shift of a signed product rounds toward -inf
            nxt = cur + ((dlt * stp) >>> 16);
            res.snap = 1'b0;
        end
        if (nxt < 0)
            nxt = 0;
        else if (nxt > longint'(FULL_LEVEL))
            nxt = longint'(FULL_LEVEL);
        chan_level[ch] = nxt[LVL_W-1:0];
        res.level = nxt[LVL_W-1:0];
        return res;
    endfunction

    task automatic send_item(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw,
                             input logic [TIME_W-1:0] dt);
        int gap;
        if (burst_left == 0) begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, dt, raw, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_levels.push_back(next_level(ch, raw, dt));
        burst_left--;
        items_sent++;
    endtask

    // Sender holds off until the pipe has delivered everything
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_levels.size() != 0);
    endtask

    task automatic write_cfg(input logic [RATE_W-1:0] rate, input logic [LVL_W-1:0] thr);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_RATE;
        i_cfg_wdata <= {8'($urandom), rate};   // upper bits must be dropped
        @(posedge i_clk);
        i_cfg_addr  <= REG_THRESH;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 16'($urandom);
        cfg_rate   = rate;
        cfg_thresh = thr;
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_levels
        t_lvl_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_levels.size() == 0) begin
                report_mismatch("unexpected transaction, channel",
                                longint'(m_axis_tdata[5:0]), -1);
            end else begin
                want = pending_levels.pop_front();
                levels_checked++;
                if (m_axis_tdata[5:0] !== want.ch)
                    report_mismatch("channel_out", longint'(m_axis_tdata[5:0]), longint'(want.ch));
                if (m_axis_tdata[21:6] !== want.level)
                    report_mismatch("brightness", longint'(m_axis_tdata[21:6]),
                                    longint'(want.level));
                if (m_axis_tuser[0] !== want.snap)
                    report_mismatch("snapped", longint'(m_axis_tuser[0]), longint'(want.snap));
            end
        end
    end

    // Reset levels and reset register values
    task automatic test_reset_levels();
        tx_gap_max   = 2;
        rx_mode      = RX_RANDOM;
        rx_stall_pct = 30;
        send_item(6'd0, 8'd255, 16'd0);        // full channel already at target
        send_item(6'd1, 8'd0, 16'hFFFF);       // zero channel at target
        send_item(6'd63, 8'd255, 16'hFFFF);    // step saturates at 1.0
        send_item(6'd2, 8'd255, 16'd0);        // zero time holds
        send_item(6'd2, 8'd255, 16'd3277);     // partial step
        send_item(6'd0, 8'd0, 16'd100);        // falling, rounds down
    endtask

    task automatic test_zero_threshold();
        wait_results_done();
        write_cfg(8'd0, 16'd0);
        send_item(6'd1, 8'd0, 16'hFFFF);       // no snap at zero diff
        send_item(6'd3, 8'd128, 16'hFFFF);     // zero rate holds
        wait_results_done();
        write_cfg(8'd255, 16'd0);
        send_item(6'd3, 8'd128, 16'hFFFF);
        send_item(6'd3, 8'd128, 16'd1);        // zero move, not snapped
        send_item(6'd4, 8'd170, 16'd85);
    endtask

    task automatic test_threshold_extremes();
        wait_results_done();
        write_cfg(8'd1, 16'hFFFF);
        send_item(6'd5, 8'd255, 16'hFFFF);     // full-scale diff is not below the max
        send_item(6'd5, 8'd0, 16'd1);          // snaps
        send_item(6'd63, 8'd0, 16'd1);         // -65535/65536 floors to -1
        send_item(6'd6, 8'd1, 16'd1);
        send_item(6'h2A, 8'h55, 16'h5555);
        send_item(6'h15, 8'hAA, 16'hAAAA);
    endtask

    // Convergence runs toward random targets mixed with stray updates
    task automatic test_random_traffic();
        logic [RATE_W-1:0] rate_set [N_PHASES];
        logic [LVL_W-1:0]  thr_set [N_PHASES];
        logic [CH_W-1:0]   hot_ch [4];
        logic [CH_W-1:0]   ch;
        logic [RAW_W-1:0]  tgt;
        logic [TIME_W-1:0] dt;
        int                seq_len;
        int                count;
        bit                paused;
        rate_set = '{8'd10, 8'd255, 8'd0, 8'd1, 8'd255, 8'd0, 8'd40, 8'd128, 8'd7, 8'd0};
        thr_set  = '{16'd66, 16'd0, 16'd500, 16'hFFFF, 16'hFFFF, 16'd0, 16'd200, 16'd1000,
                     16'd0, 16'd0};
        rate_set[5] = 8'($urandom);
        thr_set[5]  = 16'($urandom_range(0, 3000));
        rate_set[9] = 8'($urandom);
        thr_set[9]  = 16'($urandom);
        hot_ch = '{6'd0, 6'd63, 6'($urandom), 6'($urandom)};
        for (int p = 0; p < N_PHASES; p++) begin
            wait_results_done();
            write_cfg(rate_set[p], thr_set[p]);
            tx_gap_max   = (p % 4) * 3;
            rx_mode      = t_rx_mode'(p % 3);
            rx_mask      = 16'($urandom) | 16'h0001;
            rx_stall_pct = $urandom_range(10, 60);
            count  = 0;
            paused = 1'b0;
            while (count < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0)
                    ch = hot_ch[$urandom_range(0, 3)];
                else
                    ch = 6'($urandom);
                case ($urandom_range(0, 5))
                    0: tgt = 8'd0;
                    1: tgt = 8'd255;
                    default: tgt = 8'($urandom);
                endcase
                seq_len = $urandom_range(1, 10);
                for (int k = 0; k < seq_len && count < PHASE_ITEMS; k++) begin
                    case ($urandom_range(0, 7))
                        0: dt = 16'd0;
                        1: dt = 16'hFFFF;
                        2: dt = 16'($urandom);
                        default: dt = 16'($urandom_range(0, 2048));
                    endcase
                    send_item(ch, tgt, dt);
                    count++;
                    if ($urandom_range(0, 4) == 0 && count < PHASE_ITEMS) begin
                        send_item(6'($urandom), 8'($urandom), 16'($urandom));
                        count++;
                    end
                    if (!paused && count >= PHASE_ITEMS / 2) begin
                        wait_results_done();
                        paused = 1'b1;
                    end
                end
            end
            phases_run++;
        end
    endtask

    initial begin
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_addr     <= REG_RATE;
        i_cfg_wdata    <= '0;
        i_rst_n        <= 1'b0;
        rx_phase       <= '0;
        rx_mode        = RX_FREE;
        rx_mask        = 16'hFFFF;
        rx_stall_pct   = 0;
        tx_gap_max     = 0;
        burst_left     = 0;
        items_sent     = 0;
        levels_checked = 0;
        mismatches     = 0;
        phases_run     = 0;
        cycle_count    = 0;
        for (int i = 0; i < 64; i++)
            chan_level[i] = '0;
        chan_level[0] = FULL_LEVEL;
        cfg_rate   = RATE_RST;
        cfg_thresh = THR_RST;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_levels();
        test_zero_threshold();
        test_threshold_extremes();
        test_random_traffic();

        wait_results_done();
        repeat (8) @(posedge i_clk);
        $display("covered %0d transactions (%0d random phases), %0d levels checked",
                 items_sent, phases_run, levels_checked);
        $display("rate and threshold extremes, snap/hold/saturate cases, stalls and bursts");
        if (mismatches == 0) begin
            $display("[multichannel_brightness_smoother] OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[multichannel_brightness_smoother] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mbs_pkg.sv
hdl/mbs_update.sv
hdl/multichannel_brightness_smoother.sv
hdl/mbs_checker.sv
tb/tb_top.sv
